[rtl/rmq_pkg.sv]
`default_nettype none

package rmq_pkg;

	localparam int ROT_FRAC_BITS = 14;
	localparam int ROT_W = 16;
	localparam int QUAT_W_W = 15;
	localparam int POS_W = 32;
	localparam int ONE = 1 << ROT_FRAC_BITS;

	// The diagonal sum of 1.0 and three signed elements needs two guard bits.
	localparam int SUM_W = ROT_W + 2;
	localparam int DIFF_W = ROT_W + 1;
	localparam int MAG_IN_W = SUM_W - 1;
	localparam int RAD_W = ((MAG_IN_W + ROT_FRAC_BITS - 2 + 1) / 2) * 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;

	// Root bits resolved per pipeline stage; ROOT_W must be a multiple of it.
	localparam int BITS_PER_STAGE = 3;
	localparam int SQ_STAGES = ROOT_W / BITS_PER_STAGE;
	localparam int LAST = SQ_STAGES + 2;

	localparam int LANES = 4;
	localparam int LANE_W = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;
	localparam int LANE_Z = 3;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// One digit of a restoring square root: brings down two radicand bits and
	// decides one root bit.
	function automatic sq_t sqrt_step(input sq_t a);
		sq_t r;
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] trial;
		rem_n = {a.rem[REM_W-3:0], a.rad[RAD_W-1:RAD_W-2]};
		trial = REM_W'({a.root, 2'b01});
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (rem_n >= trial) begin
			r.rem = rem_n - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = rem_n;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
`default_nettype none

// Converts a 3x4 pose matrix (rotation in signed Q1.14, translation in signed
// Q16.16) into a unit quaternion in Q1.14 and passes the translation through.
// Each quaternion magnitude is floor(sqrt(S << 12)) for its signed diagonal
// sum S, clamped at zero and saturated to 1.0; x, y and z take the sign of
// their off-diagonal difference, with zero counted as positive, and w is never
// negative. The pipeline has seven register stages: one forms the sums, five
// run the square root three root bits at a time, and one saturates and signs
// the result. A matrix is taken every cycle unless a stalled output has filled
// every stage, and its result is offered from the registers of the last stage.
// Each stage holds its item while the next one is full and cannot move on, so
// a stalled output only blocks the input once every stage is occupied.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROT_W-1:0]    rot_00,
	input  logic [ROT_W-1:0]    rot_01,
	input  logic [ROT_W-1:0]    rot_02,
	input  logic [ROT_W-1:0]    rot_10,
	input  logic [ROT_W-1:0]    rot_11,
	input  logic [ROT_W-1:0]    rot_12,
	input  logic [ROT_W-1:0]    rot_20,
	input  logic [ROT_W-1:0]    rot_21,
	input  logic [ROT_W-1:0]    rot_22,
	input  logic [POS_W-1:0]    trans_x,
	input  logic [POS_W-1:0]    trans_y,
	input  logic [POS_W-1:0]    trans_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROT_W-1:0]    quat_x,
	output logic [ROT_W-1:0]    quat_y,
	output logic [ROT_W-1:0]    quat_z,
	output logic [QUAT_W_W-1:0] quat_w,
	output logic [POS_W-1:0]    pos_x,
	output logic [POS_W-1:0]    pos_y,
	output logic [POS_W-1:0]    pos_z
);

	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(ONE);
	localparam logic [ROOT_W-1:0] ONE_ROOT = ROOT_W'(ONE);

	logic [1:LAST] v_s;
	logic [1:LAST] en;

	sq_t sq_s [1:LAST-1][LANES];
	sq_t sq_nxt [2:LAST-1][LANES];
	logic [2:0] neg_s [1:LAST-1];
	logic [POS_W-1:0] pos_s [1:LAST][3];

	logic signed [SUM_W-1:0] e00, e11, e22;
	logic signed [SUM_W-1:0] sum [LANES];
	logic [RAD_W-1:0] rad_in [LANES];
	logic [DIFF_W-1:0] dx, dy, dz;

	logic [ROOT_W-1:0] mag [LANES];
	logic [ROT_W-1:0] qx_nxt, qy_nxt, qz_nxt;
	logic [ROT_W-1:0] quat_x_s7, quat_y_s7, quat_z_s7;
	logic [QUAT_W_W-1:0] quat_w_s7;

	// A stage may load when it is empty or its item moves on in this cycle.
	always_comb begin
		en[LAST] = !v_s[LAST] || out_ready;
		for (int k = LAST - 1; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[1];
	assign out_valid = v_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) begin
				v_s[1] <= in_valid;
			end
			for (int k = 2; k <= LAST; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_comb begin
		e00 = {{(SUM_W-ROT_W){rot_00[ROT_W-1]}}, rot_00};
		e11 = {{(SUM_W-ROT_W){rot_11[ROT_W-1]}}, rot_11};
		e22 = {{(SUM_W-ROT_W){rot_22[ROT_W-1]}}, rot_22};
		sum[LANE_W] = ONE_SUM + e00 + e11 + e22;
		sum[LANE_X] = ONE_SUM + e00 - e11 - e22;
		sum[LANE_Y] = ONE_SUM - e00 + e11 - e22;
		sum[LANE_Z] = ONE_SUM - e00 - e11 + e22;
		for (int l = 0; l < LANES; l++) begin
			if (sum[l][SUM_W-1]) begin
				rad_in[l] = '0;
			end else begin
				rad_in[l] = RAD_W'({sum[l][MAG_IN_W-1:0], {(ROT_FRAC_BITS-2){1'b0}}});
			end
		end
		dx = {rot_21[ROT_W-1], rot_21} - {rot_12[ROT_W-1], rot_12};
		dy = {rot_02[ROT_W-1], rot_02} - {rot_20[ROT_W-1], rot_20};
		dz = {rot_10[ROT_W-1], rot_10} - {rot_01[ROT_W-1], rot_01};
	end

	always_comb begin
		sq_t t;
		for (int k = 2; k <= LAST - 1; k++) begin
			for (int l = 0; l < LANES; l++) begin
				t = sq_s[k-1][l];
				for (int b = 0; b < BITS_PER_STAGE; b++) begin
					t = sqrt_step(t);
				end
				sq_nxt[k][l] = t;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (sq_s[LAST-1][l].root > ONE_ROOT) begin
				mag[l] = ONE_ROOT;
			end else begin
				mag[l] = sq_s[LAST-1][l].root;
			end
		end
		qx_nxt = neg_s[LAST-1][0] ? ROT_W'(0) - ROT_W'(mag[LANE_X]) : ROT_W'(mag[LANE_X]);
		qy_nxt = neg_s[LAST-1][1] ? ROT_W'(0) - ROT_W'(mag[LANE_Y]) : ROT_W'(mag[LANE_Y]);
		qz_nxt = neg_s[LAST-1][2] ? ROT_W'(0) - ROT_W'(mag[LANE_Z]) : ROT_W'(mag[LANE_Z]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < LANES; l++) begin
				sq_s[1][l] <= '{rad: rad_in[l], rem: '0, root: '0};
			end
			neg_s[1] <= {dz[DIFF_W-1], dy[DIFF_W-1], dx[DIFF_W-1]};
			pos_s[1][0] <= trans_x;
			pos_s[1][1] <= trans_y;
			pos_s[1][2] <= trans_z;
		end
		for (int k = 2; k <= LAST - 1; k++) begin
			if (en[k]) begin
				sq_s[k] <= sq_nxt[k];
				neg_s[k] <= neg_s[k-1];
				pos_s[k] <= pos_s[k-1];
			end
		end
		if (en[LAST]) begin
			quat_x_s7 <= qx_nxt;
			quat_y_s7 <= qy_nxt;
			quat_z_s7 <= qz_nxt;
			quat_w_s7 <= QUAT_W_W'(mag[LANE_W]);
			pos_s[LAST] <= pos_s[LAST-1];
		end
	end

	assign quat_x = quat_x_s7;
	assign quat_y = quat_y_s7;
	assign quat_z = quat_z_s7;
	assign quat_w = quat_w_s7;
	assign pos_x = pos_s[LAST][0];
	assign pos_y = pos_s[LAST][1];
	assign pos_z = pos_s[LAST][2];

endmodule

`default_nettype wire

[rtl/rmq_check.sv]
`default_nettype none

module rmq_check import rmq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [ROT_W-1:0]    quat_x,
	input logic [ROT_W-1:0]    quat_y,
	input logic [QUAT_W_W-1:0] quat_w
);

	localparam logic signed [ROT_W-1:0] POS_ONE = ROT_W'(ONE);
	localparam logic signed [ROT_W-1:0] NEG_ONE = -POS_ONE;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quat_x) && $stable(quat_w))
		else $error("result changed while stalled");

	// The input is refused only when the pipeline is full behind a stalled transfer.
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without backpressure");

	// The scalar part never exceeds 1.0.
	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w <= QUAT_W_W'(ONE))
		else $error("quat_w above 1.0");

	// The x and y vector parts stay within plus or minus 1.0.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(quat_x) <= POS_ONE && $signed(quat_x) >= NEG_ONE
			&& $signed(quat_y) <= POS_ONE && $signed(quat_y) >= NEG_ONE)
		else $error("vector part out of range");

endmodule

bind rotation_matrix_to_quaternion rmq_check u_rmq_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quat_x    (quat_x),
	.quat_y    (quat_y),
	.quat_w    (quat_w)
);

`default_nettype wire
